// File: sv/hpsp_pkg.sv
// Package of the parameter-set parser: field-step and phase codes, status codes,
// word layouts and the table of fixed field widths.
// Used by the top level, hpsp_front and hpsp_back; depends on nothing.
package hpsp_pkg;

   localparam int ITEM_QUEUE_DEPTH = 4;
   localparam int RSP_QUEUE_DEPTH  = 2;

   typedef enum logic [36:0] {
      H_HDR       = 37'h1,
      S_PROF      = 37'h1 << 1,
      S_CONS      = 37'h1 << 2,
      S_LEVEL     = 37'h1 << 3,
      S_SPSID     = 37'h1 << 4,
      S_CHROMA    = 37'h1 << 5,
      S_SEP       = 37'h1 << 6,
      S_DEPTHL    = 37'h1 << 7,
      S_DEPTHC    = 37'h1 << 8,
      S_BYPASS    = 37'h1 << 9,
      S_SMPRES    = 37'h1 << 10,
      S_LISTFLAG  = 37'h1 << 11,
      S_DELTA     = 37'h1 << 12,
      S_LOG2FN    = 37'h1 << 13,
      S_POCTYPE   = 37'h1 << 14,
      S_LOG2POC   = 37'h1 << 15,
      S_DPOZ      = 37'h1 << 16,
      S_OFFNR     = 37'h1 << 17,
      S_OFFTB     = 37'h1 << 18,
      S_NUMCYC    = 37'h1 << 19,
      S_OFFREF    = 37'h1 << 20,
      S_NUMREF    = 37'h1 << 21,
      S_GAPS      = 37'h1 << 22,
      S_WIDTH     = 37'h1 << 23,
      S_HEIGHT    = 37'h1 << 24,
      S_FRAMEONLY = 37'h1 << 25,
      S_MBAFF     = 37'h1 << 26,
      S_D8X8      = 37'h1 << 27,
      S_CROPF     = 37'h1 << 28,
      S_CL        = 37'h1 << 29,
      S_CR        = 37'h1 << 30,
      S_CT        = 37'h1 << 31,
      S_CB        = 37'h1 << 32,
      P_PPSID     = 37'h1 << 33,
      P_SPSID     = 37'h1 << 34,
      P_ENTROPY   = 37'h1 << 35,
      S_DONE      = 37'h1 << 36
   } fstep_type;

   typedef enum logic [3:0] {
      PH_IDLE = 4'b0001,
      PH_BITS = 4'b0010,
      PH_FIN1 = 4'b0100,
      PH_FIN2 = 4'b1000
   } phase_type;

   typedef enum logic [2:0] {
      PS_OK    = 3'd0,
      PS_SHORT = 3'd1,
      PS_TRUNC = 3'd2,
      PS_LONG  = 3'd3,
      PS_RANGE = 3'd4
   } status_type;

   typedef struct packed {
      logic       mode;
      logic       last;
      logic [7:0] data;
   } item_type;

   typedef struct packed {
      logic [7:0]  profile;
      logic [7:0]  level;
      logic [15:0] frame_width;
      logic [15:0] frame_height;
      logic        cabac_on;
      logic [2:0]  parse_status;
   } rsp_type;

   function automatic logic [3:0] step_width(input fstep_type s);
      unique case (s)
         H_HDR, S_PROF, S_CONS, S_LEVEL: step_width = 4'd8;
         S_SEP, S_BYPASS, S_SMPRES, S_LISTFLAG, S_DPOZ, S_GAPS, S_FRAMEONLY,
         S_MBAFF, S_D8X8, S_CROPF, P_ENTROPY: step_width = 4'd1;
         default: step_width = 4'd0;
      endcase
   endfunction

   function automatic logic is_high(input logic [7:0] p);
      is_high = (p == 8'd100) || (p == 8'd110) || (p == 8'd122) || (p == 8'd244) ||
                (p == 8'd44) || (p == 8'd83) || (p == 8'd86) || (p == 8'd118) ||
                (p == 8'd128) || (p == 8'd138) || (p == 8'd139) || (p == 8'd134);
   endfunction

endpackage

// File: sv/h264_parameter_set_parser.sv
// Top level of the H.264 parameter-set parser: byte queue front, bit-serial back,
// result queue and the mode register. Depends on hpsp_pkg, hpsp_front, hpsp_back
// and hpsp_fifo.
//
// Bytes of one parameter-set unit, escape bytes removed, are pushed on the req_
// channel (req_push while req_full is low), req_unit_last marking the final one.
// One result word per unit appears on the rsp_ channel: it waits while rsp_empty is
// low and leaves at rsp_pop. csr_parse_mode (0 SPS, 1 PPS) is written through the
// csr_ channel, which is always ready, and is taken at the first byte of each unit.
// The back end reads one bit per cycle while bytes are queued; bytes follow back
// to back; after the last byte, the crop arithmetic is registered before the result
// enters the result queue. A four-word byte queue lets the sender run ahead.
// If the receiver stalls, the result queue fills, the back end holds its finished
// result and then the byte queue fills and req_full rises; nothing is lost.
// Reset clears all queues, the parser state and the mode register.
module h264_parameter_set_parser #(
   parameter int MAX_CODE_ZEROS = 31,
   parameter int DIM_BITS       = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_unit_byte,
   input  logic        req_unit_last,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_profile,
   output logic [7:0]  rsp_level,
   output logic [15:0] rsp_frame_width,
   output logic [15:0] rsp_frame_height,
   output logic        rsp_cabac_on,
   output logic [2:0]  rsp_parse_status,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_parse_mode
);
   import hpsp_pkg::*;

   logic     mode_ff;
   item_type item;
   logic     item_empty, item_pop;
   logic     push, full;
   rsp_type  rsp_in, rsp_out;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else if (csr_valid) begin
         mode_ff <= csr_parse_mode;
      end
   end

   hpsp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .parse_mode(mode_ff),
      .push      (req_push),
      .unit_byte (req_unit_byte),
      .unit_last (req_unit_last),
      .full      (req_full),
      .item_pop  (item_pop),
      .item      (item),
      .item_empty(item_empty)
   );

   hpsp_back #(
      .MAX_CODE_ZEROS(MAX_CODE_ZEROS),
      .DIM_BITS      (DIM_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .item      (item),
      .item_empty(item_empty),
      .item_pop  (item_pop),
      .rsp_push  (push),
      .rsp       (rsp_in),
      .rsp_full  (full)
   );

   hpsp_fifo #(
      .WIDTH($bits(rsp_type)),
      .DEPTH(RSP_QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(rsp_in),
      .full     (full),
      .pop      (rsp_pop),
      .pop_data (rsp_out),
      .empty    (rsp_empty)
   );

   assign rsp_profile      = rsp_out.profile;
   assign rsp_level        = rsp_out.level;
   assign rsp_frame_width  = rsp_out.frame_width;
   assign rsp_frame_height = rsp_out.frame_height;
   assign rsp_cabac_on     = rsp_out.cabac_on;
   assign rsp_parse_status = rsp_out.parse_status;

endmodule

// File: sv/hpsp_fifo.sv
// Small first-in first-out queue of register words.
// Used between the parser parts and on the result side; depends on nothing.
module hpsp_fifo #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full     = (cnt_ff == CW'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

// File: sv/hpsp_front.sv
// Front part: accepts bytes, tags each with the mode of its unit, queues them.
// Depends on hpsp_pkg and hpsp_fifo.
module hpsp_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              parse_mode,
   input  logic              push,
   input  logic [7:0]        unit_byte,
   input  logic              unit_last,
   output logic              full,
   input  logic              item_pop,
   output hpsp_pkg::item_type item,
   output logic              item_empty
);
   import hpsp_pkg::*;

   logic     first_ff, first_in;
   logic     mode_ff, mode_in;
   logic     accept;
   item_type item_word;

   assign accept = push && !full;

   always_comb begin
      first_in = first_ff;
      mode_in  = mode_ff;
      if (accept) begin
         first_in = unit_last;
         if (first_ff) begin
            mode_in = parse_mode;
         end
      end
      item_word.mode = first_ff ? parse_mode : mode_ff;
      item_word.last = unit_last;
      item_word.data = unit_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= 1'b1;
         mode_ff  <= 1'b0;
      end else begin
         first_ff <= first_in;
         mode_ff  <= mode_in;
      end
   end

   hpsp_fifo #(
      .WIDTH($bits(item_type)),
      .DEPTH(ITEM_QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(item_word),
      .full     (full),
      .pop      (item_pop),
      .pop_data (item),
      .empty    (item_empty)
   );

endmodule

// File: sv/hpsp_back.sv
// Back part: decodes the queued bytes one bit per cycle while bytes are queued,
// and forms the result word. Depends on hpsp_pkg.
module hpsp_back #(
   parameter int MAX_CODE_ZEROS = 31,
   parameter int DIM_BITS       = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  hpsp_pkg::item_type item,
   input  logic              item_empty,
   output logic              item_pop,
   output logic              rsp_push,
   output hpsp_pkg::rsp_type rsp,
   input  logic              rsp_full
);
   import hpsp_pkg::*;

   phase_type   phase_ff, phase_in;
   fstep_type   step_ff, step_in;
   logic [7:0]  sr_ff, sr_in;
   logic        last_ff, last_in;
   logic        mode_ff, mode_in;
   logic [2:0]  bidx_ff, bidx_in;
   logic [2:0]  bytes_ff, bytes_in;
   logic [5:0]  bcnt_ff, bcnt_in;
   logic [5:0]  zrun_ff, zrun_in;
   logic        suffix_ff, suffix_in;
   logic [31:0] fval_ff, fval_in;
   logic [1:0]  chroma_ff, chroma_in;
   logic        fonly_ff, fonly_in;
   logic [3:0]  lidx_ff, lidx_in;
   logic [31:0] llim_ff, llim_in;
   logic [7:0]  slast_ff, slast_in;
   logic [7:0]  profile_ff, profile_in;
   logic [7:0]  level_ff, level_in;
   logic [31:0] hw_ff, hw_in, hh_ff, hh_in;
   logic [31:0] cl_ff, cl_in, cr_ff, cr_in, ct_ff, ct_in, cb_ff, cb_in;
   logic        cabac_ff, cabac_in;
   logic        err_ff, err_in;
   logic [37:0] wa_ff, wc_ff, ha_ff, hc_ff;
   status_type  base_ff, base_in;

   logic        take, fin, bit_v, unit_clear;
   logic [31:0] fin_v, shifted;
   logic [3:0]  width;
   logic [3:0]  nl_idx;
   fstep_type   nl_step;
   logic [7:0]  half, delta, snext;
   logic [31:0] llim_dec;
   logic [1:0]  ysh;
   logic [38:0] wdiff, hdiff;
   logic        bad;

   assign take     = !item_empty &&
                     ((phase_ff == PH_IDLE) ||
                      ((phase_ff == PH_BITS) && (bidx_ff == 3'd7) && !last_ff));
   assign item_pop = take;
   assign rsp_push = (phase_ff == PH_FIN2) && !rsp_full;
   assign unit_clear = rsp_push;

   always_comb begin
      phase_in = phase_ff;
      sr_in    = {sr_ff[6:0], 1'b0};
      last_in  = last_ff;
      mode_in  = mode_ff;
      bidx_in  = bidx_ff + 3'd1;
      bytes_in = bytes_ff;
      unique case (phase_ff)
         PH_IDLE: begin
         end
         PH_BITS: begin
            if (bidx_ff == 3'd7) begin
               phase_in = last_ff ? PH_FIN1 : (take ? PH_BITS : PH_IDLE);
            end
         end
         PH_FIN1: phase_in = PH_FIN2;
         PH_FIN2: begin
            if (!rsp_full) begin
               phase_in = PH_IDLE;
            end
         end
         default: phase_in = PH_IDLE;
      endcase
      if (take) begin
         phase_in = PH_BITS;
         sr_in    = item.data;
         last_in  = item.last;
         mode_in  = item.mode;
         bidx_in  = 3'd0;
         bytes_in = (bytes_ff == 3'd4) ? bytes_ff : bytes_ff + 3'd1;
      end
   end

   always_comb begin
      step_in    = step_ff;
      bcnt_in    = bcnt_ff;
      zrun_in    = zrun_ff;
      suffix_in  = suffix_ff;
      fval_in    = fval_ff;
      chroma_in  = chroma_ff;
      fonly_in   = fonly_ff;
      lidx_in    = lidx_ff;
      llim_in    = llim_ff;
      slast_in   = slast_ff;
      profile_in = profile_ff;
      level_in   = level_ff;
      hw_in      = hw_ff;
      hh_in      = hh_ff;
      cl_in      = cl_ff;
      cr_in      = cr_ff;
      ct_in      = ct_ff;
      cb_in      = cb_ff;
      cabac_in   = cabac_ff;
      err_in     = err_ff;
      fin        = 1'b0;
      fin_v      = '0;
      bit_v      = sr_ff[7];
      width      = step_width(step_ff);
      shifted    = {fval_ff[30:0], bit_v};
      nl_idx     = lidx_ff + 4'd1;
      nl_step    = (nl_idx < ((chroma_ff == 2'd3) ? 4'd12 : 4'd8)) ? S_LISTFLAG : S_LOG2FN;
      half       = 8'(fin_v >> 1);
      delta      = '0;
      snext      = '0;
      llim_dec   = llim_ff - 32'd1;

      if ((phase_ff == PH_BITS) && (step_ff != S_DONE)) begin
         if (width != 4'd0) begin
            fval_in = shifted;
            bcnt_in = bcnt_ff + 6'd1;
            if (({1'b0, bcnt_ff} + 7'd1) >= {3'b0, width}) begin
               fin   = 1'b1;
               fin_v = shifted;
            end
         end else if (!suffix_ff) begin
            if (!bit_v) begin
               zrun_in = zrun_ff + 6'd1;
               if (zrun_in > 6'(MAX_CODE_ZEROS)) begin
                  err_in  = 1'b1;
                  step_in = S_DONE;
               end
            end else if (zrun_ff == 6'd0) begin
               fin = 1'b1;
            end else begin
               suffix_in = 1'b1;
               fval_in   = '0;
               bcnt_in   = '0;
            end
         end else begin
            fval_in = shifted;
            bcnt_in = bcnt_ff + 6'd1;
            if (({1'b0, bcnt_ff} + 7'd1) >= {1'b0, zrun_ff}) begin
               fin   = 1'b1;
               fin_v = 32'((33'd1 << zrun_ff) - 33'd1 + {1'b0, shifted});
            end
         end
      end

      half  = 8'(fin_v >> 1);
      delta = fin_v[0] ? half + 8'd1 : 8'd0 - half;
      snext = slast_ff + delta;

      if (fin) begin
         fval_in   = '0;
         bcnt_in   = '0;
         zrun_in   = '0;
         suffix_in = 1'b0;
         unique case (step_ff)
            H_HDR:   step_in = mode_ff ? P_PPSID : S_PROF;
            S_PROF: begin
               profile_in = fin_v[7:0];
               if (is_high(fin_v[7:0])) begin
                  chroma_in = 2'd0;
               end
               step_in = S_CONS;
            end
            S_CONS:  step_in = S_LEVEL;
            S_LEVEL: begin
               level_in = fin_v[7:0];
               step_in  = S_SPSID;
            end
            S_SPSID: step_in = is_high(profile_ff) ? S_CHROMA : S_LOG2FN;
            S_CHROMA: begin
               chroma_in = (fin_v <= 32'd3) ? fin_v[1:0] : 2'd0;
               step_in   = (fin_v == 32'd3) ? S_SEP : S_DEPTHL;
            end
            S_SEP:    step_in = S_DEPTHL;
            S_DEPTHL: step_in = S_DEPTHC;
            S_DEPTHC: step_in = S_BYPASS;
            S_BYPASS: step_in = S_SMPRES;
            S_SMPRES: begin
               lidx_in = '0;
               step_in = (fin_v != '0) ? S_LISTFLAG : S_LOG2FN;
            end
            S_LISTFLAG: begin
               if (fin_v != '0) begin
                  llim_in  = (lidx_ff < 4'd6) ? 32'd16 : 32'd64;
                  slast_in = 8'd8;
                  step_in  = S_DELTA;
               end else begin
                  lidx_in = nl_idx;
                  step_in = nl_step;
               end
            end
            S_DELTA: begin
               if (snext != 8'd0) begin
                  slast_in = snext;
               end
               llim_in = llim_dec;
               if ((llim_dec == '0) || (snext == 8'd0)) begin
                  lidx_in = nl_idx;
                  step_in = nl_step;
               end
            end
            S_LOG2FN:  step_in = S_POCTYPE;
            S_POCTYPE: begin
               step_in = (fin_v == 32'd0) ? S_LOG2POC :
                         (fin_v == 32'd1) ? S_DPOZ : S_NUMREF;
            end
            S_LOG2POC: step_in = S_NUMREF;
            S_DPOZ:    step_in = S_OFFNR;
            S_OFFNR:   step_in = S_OFFTB;
            S_OFFTB:   step_in = S_NUMCYC;
            S_NUMCYC: begin
               llim_in = fin_v;
               step_in = (fin_v != '0) ? S_OFFREF : S_NUMREF;
            end
            S_OFFREF: begin
               llim_in = llim_dec;
               if (llim_dec == '0) begin
                  step_in = S_NUMREF;
               end
            end
            S_NUMREF: step_in = S_GAPS;
            S_GAPS:   step_in = S_WIDTH;
            S_WIDTH: begin
               hw_in   = fin_v;
               step_in = S_HEIGHT;
            end
            S_HEIGHT: begin
               hh_in   = fin_v;
               step_in = S_FRAMEONLY;
            end
            S_FRAMEONLY: begin
               fonly_in = fin_v[0];
               step_in  = fin_v[0] ? S_D8X8 : S_MBAFF;
            end
            S_MBAFF: step_in = S_D8X8;
            S_D8X8:  step_in = S_CROPF;
            S_CROPF: step_in = (fin_v != '0) ? S_CL : S_DONE;
            S_CL: begin
               cl_in   = fin_v;
               step_in = S_CR;
            end
            S_CR: begin
               cr_in   = fin_v;
               step_in = S_CT;
            end
            S_CT: begin
               ct_in   = fin_v;
               step_in = S_CB;
            end
            S_CB: begin
               cb_in   = fin_v;
               step_in = S_DONE;
            end
            P_PPSID:   step_in = P_SPSID;
            P_SPSID:   step_in = P_ENTROPY;
            P_ENTROPY: begin
               cabac_in = fin_v[0];
               step_in  = S_DONE;
            end
            default: step_in = S_DONE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
      sr_ff   <= sr_in;
      last_ff <= last_in;
      bidx_ff <= bidx_in;
   end

   always_ff @(posedge clock) begin
      if (reset || unit_clear) begin
         mode_ff    <= 1'b0;
         bytes_ff   <= '0;
         step_ff    <= H_HDR;
         bcnt_ff    <= '0;
         zrun_ff    <= '0;
         suffix_ff  <= 1'b0;
         fval_ff    <= '0;
         chroma_ff  <= 2'd1;
         fonly_ff   <= 1'b0;
         lidx_ff    <= '0;
         llim_ff    <= '0;
         slast_ff   <= 8'd8;
         profile_ff <= '0;
         level_ff   <= '0;
         hw_ff      <= '0;
         hh_ff      <= '0;
         cl_ff      <= '0;
         cr_ff      <= '0;
         ct_ff      <= '0;
         cb_ff      <= '0;
         cabac_ff   <= 1'b0;
         err_ff     <= 1'b0;
      end else begin
         mode_ff    <= mode_in;
         bytes_ff   <= bytes_in;
         step_ff    <= step_in;
         bcnt_ff    <= bcnt_in;
         zrun_ff    <= zrun_in;
         suffix_ff  <= suffix_in;
         fval_ff    <= fval_in;
         chroma_ff  <= chroma_in;
         fonly_ff   <= fonly_in;
         lidx_ff    <= lidx_in;
         llim_ff    <= llim_in;
         slast_ff   <= slast_in;
         profile_ff <= profile_in;
         level_ff   <= level_in;
         hw_ff      <= hw_in;
         hh_ff      <= hh_in;
         cl_ff      <= cl_in;
         cr_ff      <= cr_in;
         ct_ff      <= ct_in;
         cb_ff      <= cb_in;
         cabac_ff   <= cabac_in;
         err_ff     <= err_in;
      end
   end

   always_comb begin
      ysh = {1'b0, chroma_ff == 2'd1} + {1'b0, !fonly_ff};
      if (bytes_ff < (mode_ff ? 3'd1 : 3'd4)) begin
         base_in = PS_SHORT;
      end else if (err_ff) begin
         base_in = PS_LONG;
      end else if (step_ff != S_DONE) begin
         base_in = PS_TRUNC;
      end else begin
         base_in = PS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (phase_ff == PH_FIN1) begin
         wa_ff   <= ({6'd0, hw_ff} + 38'd1) << 4;
         ha_ff   <= (({6'd0, hh_ff} + 38'd1) << 4) << !fonly_ff;
         wc_ff   <= ({6'd0, cl_ff} + {6'd0, cr_ff}) <<
                    ((chroma_ff == 2'd1) || (chroma_ff == 2'd2));
         hc_ff   <= ({6'd0, ct_ff} + {6'd0, cb_ff}) << ysh;
         base_ff <= base_in;
      end
   end

   always_comb begin
      wdiff = {1'b0, wa_ff} - {1'b0, wc_ff};
      hdiff = {1'b0, ha_ff} - {1'b0, hc_ff};
      bad   = wdiff[38] || hdiff[38] || (|wdiff[37:DIM_BITS]) || (|hdiff[37:DIM_BITS]);
      rsp   = '0;
      if (base_ff == PS_SHORT) begin
         rsp.parse_status = PS_SHORT;
      end else if (mode_ff) begin
         rsp.cabac_on     = cabac_ff;
         rsp.parse_status = base_ff;
      end else begin
         rsp.profile      = profile_ff;
         rsp.level        = level_ff;
         rsp.frame_width  = bad ? 16'd0 : wdiff[15:0];
         rsp.frame_height = bad ? 16'd0 : hdiff[15:0];
         rsp.parse_status = (base_ff != PS_OK) ? base_ff : (bad ? PS_RANGE : PS_OK);
      end
   end

   a_push_in_fin2: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> (phase_ff == PH_FIN2))
      else $error("result pushed outside the final phase");
   a_fin_follow: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_FIN1) |=> (phase_ff == PH_FIN2))
      else $error("finish phases out of order");
   a_clear_after_push: assert property (@(posedge clock) disable iff (reset)
      rsp_push |=> ((step_ff == H_HDR) && (bytes_ff == 3'd0) && (phase_ff == PH_IDLE)))
      else $error("unit state not cleared after result");
   a_no_pop_midbyte: assert property (@(posedge clock) disable iff (reset)
      ((phase_ff == PH_BITS) && (bidx_ff != 3'd7)) |-> !item_pop)
      else $error("byte taken before the current byte is done");

endmodule
